// ----- rtl/adb_pkg.sv -----
// Shared types and constants for the ADC delta block encoder.
// No dependencies; every other rtl file refers to this package by scoped names.
package adb_pkg;

  localparam int CHANNELS = 64;            // channels per sample row, multiple of 4
  localparam int LANES    = 4;             // samples per block
  localparam int ROWS     = CHANNELS / LANES;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int SAMPLE_W = 12;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int WORD_W   = 16;
  localparam int COUNT_W  = 24;

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] REQ_HEADER  = 2'd0;
  localparam logic [1:0] REQ_BLOCK   = 2'd1;
  localparam logic [1:0] REQ_TRAILER = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;

  localparam logic [WORD_W-1:0]   RAW_FLAG    = 16'h8000;
  localparam logic [WORD_W-1:0]   NIBBLE_MASK = 16'h000F;
  localparam logic [WORD_W-1:0]   SAMPLE_MASK = 16'h0FFF;
  localparam logic signed [DIFF_W-1:0] SMALL_LIM = 13'sd8;
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = 24'hFFFFFF;

  // One classified item waiting for the serializer.
  typedef struct packed {
    logic [LANES-1:0][WORD_W-1:0] words;  // words[0] alone when not wide
    logic                         wide;   // four words instead of one
    logic                         spacer; // append a zero word
    logic                         tile_end;
  } entry_t;

endpackage

// ----- rtl/adb_if.sv -----
// Valid/ready stream interfaces for the encoder's input items and output words.
// Depends on adb_pkg for field widths.
interface adb_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         req_type;
  logic [adb_pkg::WORD_W-1:0]         raw_word;
  logic [adb_pkg::SAMPLE_W-1:0]       adc_0;
  logic [adb_pkg::SAMPLE_W-1:0]       adc_1;
  logic [adb_pkg::SAMPLE_W-1:0]       adc_2;
  logic [adb_pkg::SAMPLE_W-1:0]       adc_3;
  logic [5:0]                         block_index;
  logic                               first_row;
  logic                               row_end;
  logic                               tile_end;

  modport source (output valid, req_type, raw_word, adc_0, adc_1, adc_2, adc_3,
                  block_index, first_row, row_end, tile_end, input ready);
  modport sink   (input valid, req_type, raw_word, adc_0, adc_1, adc_2, adc_3,
                  block_index, first_row, row_end, tile_end, output ready);
endinterface

interface adb_out_if;
  logic                               valid;
  logic                               ready;
  logic [adb_pkg::WORD_W-1:0]         out_word;
  logic                               last;
  logic [adb_pkg::COUNT_W-1:0]        tile_bytes;
  logic                               tile_done;

  modport source (output valid, out_word, last, tile_bytes, tile_done, input ready);
  modport sink   (input valid, out_word, last, tile_bytes, tile_done, output ready);
endinterface

// ----- rtl/adb_front.sv -----
// Front end: accepts items, looks up previous samples, classifies blocks.
// Depends on adb_pkg and adb_in_if.
module adb_front (
  input  logic            clk,
  input  logic            rst,
  adb_in_if.sink          item,
  output logic            push_valid,
  input  logic            push_ready,
  output adb_pkg::entry_t push_entry
);

  localparam int SW = adb_pkg::SAMPLE_W;
  localparam int DW = adb_pkg::DIFF_W;
  localparam int RW = adb_pkg::ROW_W;

  // Stage 1: item held while previous row data is read.
  logic                                  s1_valid;
  logic [1:0]                            s1_req;
  logic [adb_pkg::WORD_W-1:0]            s1_raw;
  logic [adb_pkg::LANES-1:0][SW-1:0]     s1_cur;
  logic [RW-1:0]                         s1_row;
  logic                                  s1_first;
  logic                                  s1_rend;
  logic                                  s1_tend;

  logic [adb_pkg::LANES*SW-1:0]          mem [adb_pkg::ROWS];
  logic [adb_pkg::LANES*SW-1:0]          rd_data;
  logic [adb_pkg::LANES*SW-1:0]          wr_data;
  logic                                  wr_en;

  logic                                  odd_packed;
  logic                                  odd_packed_next;
  logic                                  accept;
  logic                                  advance;
  logic [RW-1:0]                         in_row;

  // one signed difference per lane
  logic signed [DW-1:0]                  diff [adb_pkg::LANES];
  logic                                  fits_nibble;
  logic                                  packed_blk;
  logic                                  odd_after;

  assign in_row  = RW'(item.block_index % adb_pkg::ROWS);
  assign advance = s1_valid && (push_ready || s1_req == adb_pkg::REQ_RSVD);
  assign item.ready = !s1_valid || advance;
  assign accept  = item.valid && item.ready;

  assign wr_en   = advance && s1_req == adb_pkg::REQ_BLOCK;
  assign wr_data = s1_cur;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_row] <= wr_data;
    end
    if (accept) begin
      // write-through when the next block hits the row being stored
      rd_data <= (wr_en && s1_row == in_row) ? wr_data : mem[in_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req    <= item.req_type;
      s1_raw    <= item.raw_word;
      s1_cur[0] <= item.adc_0;
      s1_cur[1] <= item.adc_1;
      s1_cur[2] <= item.adc_2;
      s1_cur[3] <= item.adc_3;
      s1_row    <= in_row;
      s1_first  <= item.first_row;
      s1_rend   <= item.row_end;
      s1_tend   <= item.tile_end;
    end
  end

  always_comb begin
    fits_nibble = 1'b1;
    for (int k = 0; k < adb_pkg::LANES; k++) begin
      diff[k] = $signed({1'b0, s1_cur[k]}) - $signed({1'b0, rd_data[k*SW +: SW]});
      if (diff[k] >= adb_pkg::SMALL_LIM || diff[k] <= -adb_pkg::SMALL_LIM) begin
        fits_nibble = 1'b0;
      end
    end
  end

  assign packed_blk = !s1_first && fits_nibble;
  assign odd_after  = odd_packed ^ packed_blk;

  always_comb begin
    push_entry          = '0;
    push_entry.tile_end = (s1_req == adb_pkg::REQ_TRAILER) && s1_tend;
    if (s1_req == adb_pkg::REQ_BLOCK) begin
      push_entry.spacer = s1_rend && odd_after;
      if (s1_first) begin
        push_entry.wide = 1'b1;
        for (int k = 0; k < adb_pkg::LANES; k++) begin
          push_entry.words[k] = adb_pkg::RAW_FLAG | {{(adb_pkg::WORD_W-SW){1'b0}}, s1_cur[k]};
        end
      end else if (fits_nibble) begin
        for (int k = 0; k < adb_pkg::LANES; k++) begin
          push_entry.words[0][k*4 +: 4] = diff[k][3:0];
        end
      end else begin
        push_entry.wide = 1'b1;
        for (int k = 0; k < adb_pkg::LANES; k++) begin
          push_entry.words[k] = adb_pkg::RAW_FLAG
              | (adb_pkg::SAMPLE_MASK & {{(adb_pkg::WORD_W-DW){diff[k][DW-1]}}, diff[k]});
        end
      end
    end else begin
      push_entry.words[0] = s1_raw;
    end
  end

  assign push_valid = s1_valid && s1_req != adb_pkg::REQ_RSVD;

  always_comb begin
    odd_packed_next = odd_packed;
    if (wr_en) begin
      odd_packed_next = s1_rend ? 1'b0 : odd_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      odd_packed <= 1'b0;
    end else begin
      odd_packed <= odd_packed_next;
    end
  end

endmodule

// ----- rtl/adb_queue.sv -----
// Short queue of classified entries between the front end and the serializer.
// Depends on adb_pkg.
module adb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  adb_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output adb_pkg::entry_t pop_entry
);

  adb_pkg::entry_t               slots [adb_pkg::Q_DEPTH];
  logic [adb_pkg::QPTR_W-1:0]    wr_ptr;
  logic [adb_pkg::QPTR_W-1:0]    rd_ptr;
  logic [adb_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          pop;

  assign push_ready = count != adb_pkg::QCNT_W'(adb_pkg::Q_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == adb_pkg::QPTR_W'(adb_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == adb_pkg::QPTR_W'(adb_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/adb_back.sv -----
// Back end: serializes queue entries into words, keeps the tile byte count.
// Depends on adb_pkg and adb_out_if.
module adb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  adb_pkg::entry_t pop_entry,
  adb_out_if.source       result
);

  localparam int CW = adb_pkg::COUNT_W;

  logic [2:0]                   idx;
  logic [2:0]                   total;
  logic                         last_word;
  logic                         load;
  logic                         in_data;
  logic                         done;
  logic [adb_pkg::WORD_W-1:0]   word;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_inc;
  logic [CW-1:0]                bytes;

  logic                         out_valid;
  logic [adb_pkg::WORD_W-1:0]   out_word;
  logic                         out_last;
  logic [CW-1:0]                out_bytes;
  logic                         out_done;

  assign total     = (pop_entry.wide ? 3'd4 : 3'd1) + {2'b0, pop_entry.spacer};
  assign last_word = idx == total - 3'd1;
  assign in_data   = pop_entry.wide ? !idx[2] : (idx == 3'd0);
  assign word      = in_data ? pop_entry.words[idx[1:0]] : '0;
  assign done      = last_word && pop_entry.tile_end;

  assign load      = pop_valid && (!out_valid || result.ready);
  assign pop_ready = load && last_word;

  // count includes the word being loaded; bytes saturate
  assign count_inc = (count == adb_pkg::COUNT_MAX) ? count : count + 1'b1;
  assign bytes     = count_inc[CW-1] ? adb_pkg::COUNT_MAX : {count_inc[CW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last_word ? 3'd0 : idx + 3'd1;
        count     <= done ? '0 : count_inc;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word  <= word;
      out_last  <= last_word;
      out_bytes <= done ? bytes : '0;
      out_done  <= done;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_word   = out_word;
  assign result.last       = out_last;
  assign result.tile_bytes = out_bytes;
  assign result.tile_done  = out_done;

endmodule

// ----- rtl/adc_delta_block_encoder.sv -----
// Top level of the ADC delta block encoder: front end, queue, serializer.
// Depends on adb_pkg, adb_if, adb_front, adb_queue, adb_back.
//
//   channel  direction  transfer unit                         handshake
//   item     in         header/trailer word or 4-sample block valid/ready
//   result   out        one 16-bit stream word + tile status  valid/ready
//
// Rates: the front end takes one item per cycle while the queue has room; the
// serializer puts out one word per cycle while the receiver is ready, so a block
// takes 1 to 5 words (one packed word or four raw or difference words, plus an
// optional zero spacer). The single-word output port sets the sustained rate.
// Reset: rst clears handshake state, queue, row parity and tile count; the
// previous-sample store is not cleared and must be written by a first row.
// Stalls: a two-entry queue separates the sides; the front keeps accepting
// until the queue is full while a finished word waits in the output register.
module adc_delta_block_encoder (
  input  logic      clk,
  input  logic      rst,
  adb_in_if.sink    item,
  adb_out_if.source result
);

  // front end -> queue
  logic            push_valid;
  logic            push_ready;
  adb_pkg::entry_t push_entry;

  // queue -> serializer
  logic            pop_valid;
  logic            pop_ready;
  adb_pkg::entry_t pop_entry;

  // Front end: stage register plus previous-sample store. Blocks are
  // classified as first-row, packed (all deltas within +-7) or wide, and the
  // packed-word parity of the row decides whether a spacer follows.
  adb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  adb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Serializer: walks each entry one word per transfer, flags the last word,
  // and reports the saturating byte count on the tile's final trailer word.
  adb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .result    (result)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for adc_delta_block_encoder: directed and random tiles on the item channel.
// Depends on adb_pkg and the adb_in_if / adb_out_if stream interfaces.
module tb;
  import adb_pkg::*;

  // Item as queued by the generator, plus the pacing hints the driver applies.
  typedef struct {
    logic [1:0]                      req_type;
    logic [WORD_W-1:0]               raw_word;
    logic [LANES-1:0][SAMPLE_W-1:0]  adc;
    logic [5:0]                      block_index;
    logic                            first_row;
    logic                            row_end;
    logic                            tile_end;
    int unsigned                     gap;      // idle cycles after this transfer
    bit                              drain;    // wait for all words before offering
    bit                              hold_rx;  // receiver holds off when this is offered
    bit                              rx_fast;  // receiver never stalls while this is current
  } item_t;

  typedef struct {
    logic [WORD_W-1:0]  out_word;
    logic               last;
    logic [COUNT_W-1:0] tile_bytes;
    logic               tile_done;
  } word_t;

  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS  = 150;

  logic clk;
  logic rst;

  adb_in_if  item_bus ();
  adb_out_if result_bus ();

  adc_delta_block_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder state as the bench predicts it
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] prev_sample [0:CHANNELS-1];
  logic                odd_packed;
  logic [COUNT_W-1:0]  word_count;

  word_t expected_words [$];
  int    error_count;

  task automatic report_error(input string msg);
    $display("[tb] mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Work out the stream words one accepted item produces and queue them.
  task automatic encode_item(input item_t it);
    logic [WORD_W-1:0]        words [0:4];
    logic signed [DIFF_W-1:0] delta [0:LANES-1];
    logic [COUNT_W:0]         bytes;
    word_t                    w;
    int                       n;
    int                       ch;
    int                       k;
    bit                       fits;
    bit                       closes_tile;
    n = 0;
    fits = 1'b1;
    case (it.req_type)
      REQ_HEADER, REQ_TRAILER: begin
        words[0] = it.raw_word;
        n = 1;
      end
      REQ_BLOCK: begin
        for (k = 0; k < LANES; k++) begin
          ch = (int'(it.block_index) * LANES + k) % CHANNELS;
          delta[k] = $signed({1'b0, it.adc[k]}) - $signed({1'b0, prev_sample[ch]});
          if (delta[k] >= 8 || delta[k] <= -8)
            fits = 1'b0;
          prev_sample[ch] = it.adc[k];
        end
        if (it.first_row) begin
          for (k = 0; k < LANES; k++)
            words[k] = RAW_FLAG | {4'h0, it.adc[k]};
          n = LANES;
        end else if (fits) begin
          // channel 0 sits in the low nibble
          words[0] = {delta[3][3:0], delta[2][3:0], delta[1][3:0], delta[0][3:0]};
          n = 1;
          odd_packed = ~odd_packed;
        end else begin
          for (k = 0; k < LANES; k++)
            words[k] = RAW_FLAG | {4'h0, delta[k][SAMPLE_W-1:0]};
          n = LANES;
        end
        if (it.row_end) begin
          if (odd_packed) begin
            words[n] = '0;   // spacer keeps the row word-aligned
            n++;
          end
          odd_packed = 1'b0;
        end
      end
      default: ;  // reserved type: no words, no state change
    endcase

    for (k = 0; k < n; k++)
      if (word_count != COUNT_MAX)
        word_count++;

    closes_tile = (it.req_type == REQ_TRAILER) && it.tile_end;
    bytes = {word_count, 1'b0};
    if (bytes > COUNT_MAX)
      bytes = COUNT_MAX;

    for (k = 0; k < n; k++) begin
      w.out_word   = words[k];
      w.last       = (k == n - 1);
      w.tile_done  = closes_tile && w.last;
      w.tile_bytes = w.tile_done ? bytes[COUNT_W-1:0] : '0;
      expected_words.push_back(w);
    end
    if (closes_tile)
      word_count = '0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generator state: mirrors written channels so that no difference
  // row ever reads a channel that was never stored.
  // ---------------------------------------------------------------------------
  item_t               pending_items [$];
  logic [SAMPLE_W-1:0] gen_prev    [0:CHANNELS-1];
  bit                  gen_written [0:CHANNELS-1];
  bit                  tx_fast;
  bit                  rx_fast_mode;
  bit                  drain_next;
  bit                  hold_next;

  task automatic queue_item(input logic [1:0] req, input logic [WORD_W-1:0] raw,
                            input logic [SAMPLE_W-1:0] a0, a1, a2, a3,
                            input logic [5:0] blk, input bit first, rend, tend);
    item_t s;
    int    ch;
    int    k;
    s.req_type    = req;
    s.raw_word    = raw;
    s.adc[0]      = a0;
    s.adc[1]      = a1;
    s.adc[2]      = a2;
    s.adc[3]      = a3;
    s.block_index = blk;
    s.first_row   = first;
    s.row_end     = rend;
    s.tile_end    = tend;
    if (req == REQ_BLOCK) begin
      for (k = 0; k < LANES; k++) begin
        ch = (int'(blk) * LANES + k) % CHANNELS;
        if (!gen_written[ch])
          s.first_row = 1'b1;
      end
      for (k = 0; k < LANES; k++) begin
        ch = (int'(blk) * LANES + k) % CHANNELS;
        gen_written[ch] = 1'b1;
        gen_prev[ch]    = s.adc[k];
      end
    end
    s.gap     = tx_fast ? 0 : $urandom_range(0, 5);
    s.drain   = drain_next;
    s.hold_rx = hold_next;
    s.rx_fast = rx_fast_mode;
    drain_next = 1'b0;
    hold_next  = 1'b0;
    pending_items.push_back(s);
  endtask

  function automatic logic [SAMPLE_W-1:0] near_sample(input logic [SAMPLE_W-1:0] p,
                                                      input int spread);
    int v;
    v = int'(p) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0)
      v = 0;
    if (v > 4095)
      v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // Mostly small steps so packing is common; some wider steps and full noise.
  task automatic queue_random_block(input logic [5:0] blk, input bit first, rend);
    logic [SAMPLE_W-1:0] s [0:LANES-1];
    int                  style;
    int                  k;
    int                  ch;
    style = $urandom_range(0, 9);
    for (k = 0; k < LANES; k++) begin
      ch = (int'(blk) * LANES + k) % CHANNELS;
      if (style <= 5)
        s[k] = near_sample(gen_prev[ch], 7);
      else if (style <= 7)
        s[k] = near_sample(gen_prev[ch], 12);
      else
        s[k] = $urandom_range(0, 4095);
    end
    queue_item(REQ_BLOCK, $urandom, s[0], s[1], s[2], s[3], blk, first, rend,
               $urandom_range(0, 1));
  endtask

  task automatic queue_noise;
    queue_item(REQ_RSVD, $urandom, $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 63),
               $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic fill_stimulus;
    int tile_no;
    int rows;
    int blocks;
    int r;
    int b;
    int t;
    int target;
    tx_fast = 1'b0;
    rx_fast_mode = 1'b0;

    // Directed: extremes, every request type and the named corner cases.
    queue_item(REQ_HEADER, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_item(REQ_HEADER, 16'hFFFF, 4095, 4095, 4095, 4095, 63, 1, 1, 1); // tile_end ignored
    queue_item(REQ_RSVD, 16'hA5A5, 1, 2, 3, 4, 5, 1, 1, 1);                 // dropped
    queue_item(REQ_BLOCK, 0, 0, 4095, 7, 2048, 0, 1, 0, 1);                 // tile_end ignored
    queue_item(REQ_BLOCK, 0, 100, 200, 300, 400, 1, 1, 0, 0);
    queue_item(REQ_BLOCK, 0, 7, 4088, 0, 2048, 0, 0, 0, 0);                 // +7 -7 -7 0
    queue_item(REQ_BLOCK, 0, 100, 200, 300, 400, 1, 1, 1, 0);               // spacer on first row
    queue_item(REQ_BLOCK, 0, 15, 4080, 0, 2048, 0, 0, 0, 0);                // +8 -8: raw
    queue_item(REQ_BLOCK, 0, 4095, 0, 4095, 0, 0, 0, 0, 0);                 // widest steps
    queue_item(REQ_BLOCK, 0, 4095, 0, 4095, 0, 16, 0, 1, 0);                // index wraps
    queue_item(REQ_BLOCK, 0, 4095, 4095, 4095, 4095, 63, 1, 1, 0);
    queue_item(REQ_BLOCK, 0, 4090, 4094, 4088, 4095, 47, 0, 1, 0);          // wraps, spacer
    queue_item(REQ_BLOCK, 0, 4094, 1, 4095, 0, 0, 0, 0, 0);
    queue_item(REQ_BLOCK, 0, 4094, 1, 4095, 0, 16, 0, 1, 0);                // even: no spacer
    queue_item(REQ_TRAILER, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_item(REQ_TRAILER, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 1);              // tile closes
    queue_item(REQ_TRAILER, 16'h5678, 0, 0, 0, 0, 0, 0, 0, 1);              // one-word tile
    queue_item(REQ_HEADER, 16'h00FF, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_item(REQ_RSVD, 16'h0F0F, 0, 0, 0, 0, 0, 0, 0, 1);
    queue_item(REQ_TRAILER, 16'hFF00, 0, 0, 0, 0, 0, 0, 0, 1);

    // Random tiles: headers, rows of blocks, trailers; some noise and open tiles.
    target = pending_items.size() + RANDOM_ITEMS;
    tile_no = 0;
    while (pending_items.size() < target) begin
      tx_fast      = ($urandom_range(0, 3) == 0);
      rx_fast_mode = ($urandom_range(0, 3) == 0);
      if (tile_no == 2 || tile_no == 7)
        drain_next = 1'b1;
      if (tile_no == 4) begin
        hold_next = 1'b1;   // receiver stops while the sender keeps going
        tx_fast   = 1'b1;
      end
      for (t = 0; t < $urandom_range(1, 2); t++)
        queue_item(REQ_HEADER, $urandom, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 1));
      rows = $urandom_range(1, 3);
      for (r = 0; r < rows; r++) begin
        blocks = $urandom_range(1, 5);
        for (b = 0; b < blocks; b++) begin
          queue_random_block($urandom_range(0, 63), (r == 0) && ($urandom_range(0, 2) == 0),
                             b == blocks - 1);
          if ($urandom_range(0, 11) == 0)
            queue_noise();
        end
      end
      for (t = $urandom_range(1, 2); t > 0; t--)
        queue_item(REQ_TRAILER, $urandom, 0, 0, 0, 0, 0, 0, 0,
                   (t == 1) && ($urandom_range(0, 5) != 0));
      tile_no++;
    end
    tx_fast = 1'b0;
    drain_next = 1'b1;
    queue_item(REQ_TRAILER, $urandom, 0, 0, 0, 0, 0, 0, 0, 1);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: acceptance seen at the rising edge, next item put up at the falling
  // edge. valid stays high across back-to-back transfers.
  // ---------------------------------------------------------------------------
  item_t       cur_item;
  logic        item_taken;
  int unsigned gap_left;
  int unsigned hold_token;
  bit          rx_fast_cur;

  always @(posedge clk) begin
    if (!rst && item_bus.valid && item_bus.ready) begin
      encode_item(cur_item);
      item_taken <= 1'b1;
    end else begin
      item_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
      gap_left       <= 0;
    end else if (item_bus.valid && !item_taken) begin
      // still waiting for the transfer
    end else if (gap_left != 0) begin
      item_bus.valid <= 1'b0;
      gap_left       <= gap_left - 1;
    end else if (pending_items.size() == 0) begin
      item_bus.valid <= 1'b0;
    end else if (pending_items[0].drain && expected_words.size() != 0) begin
      item_bus.valid <= 1'b0;   // pause until all expected words have come out
    end else begin
      cur_item = pending_items.pop_front();
      item_bus.req_type    <= cur_item.req_type;
      item_bus.raw_word    <= cur_item.raw_word;
      item_bus.adc_0       <= cur_item.adc[0];
      item_bus.adc_1       <= cur_item.adc[1];
      item_bus.adc_2       <= cur_item.adc[2];
      item_bus.adc_3       <= cur_item.adc[3];
      item_bus.block_index <= cur_item.block_index;
      item_bus.first_row   <= cur_item.first_row;
      item_bus.row_end     <= cur_item.row_end;
      item_bus.tile_end    <= cur_item.tile_end;
      item_bus.valid       <= 1'b1;
      gap_left             <= cur_item.gap;
      rx_fast_cur          <= cur_item.rx_fast;
      if (cur_item.hold_rx)
        hold_token <= hold_token + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each word transfer is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  word_t got_want;
  logic  word_taken;

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      word_taken <= 1'b1;
      if (expected_words.size() == 0) begin
        report_error($sformatf("unexpected word %0h", result_bus.out_word));
      end else begin
        got_want = expected_words.pop_front();
        check_field("out_word", result_bus.out_word, got_want.out_word);
        check_field("last", result_bus.last, got_want.last);
        check_field("tile_bytes", result_bus.tile_bytes, got_want.tile_bytes);
        check_field("tile_done", result_bus.tile_done, got_want.tile_done);
      end
    end else begin
      word_taken <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each transfer, plus one long hold-off that it
  // counts down itself once the driver bumps hold_token.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned hold_seen;
  int unsigned stall_draw;

  always @(negedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left       <= 0;
      hold_left        <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen        <= hold_token;
      hold_left        <= HOLD_CYCLES;
      result_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left        <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else if (word_taken) begin
      stall_draw = rx_fast_cur ? 0 : $urandom_range(0, 5);
      stall_left       <= (stall_draw == 0) ? 0 : stall_draw - 1;
      result_bus.ready <= (stall_draw == 0);
    end else if (stall_left != 0) begin
      stall_left       <= stall_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    rst                  = 1'b1;
    item_bus.valid       = 1'b0;
    item_bus.req_type    = REQ_HEADER;
    item_bus.raw_word    = '0;
    item_bus.adc_0       = '0;
    item_bus.adc_1       = '0;
    item_bus.adc_2       = '0;
    item_bus.adc_3       = '0;
    item_bus.block_index = '0;
    item_bus.first_row   = 1'b0;
    item_bus.row_end     = 1'b0;
    item_bus.tile_end    = 1'b0;
    result_bus.ready     = 1'b0;
    item_taken           = 1'b0;
    word_taken           = 1'b0;
    hold_token           = 0;
    hold_seen            = 0;
    rx_fast_cur          = 1'b0;
    error_count          = 0;
    odd_packed           = 1'b0;
    word_count           = '0;
    drain_next           = 1'b0;
    hold_next            = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      prev_sample[c] = '0;
      gen_prev[c]    = '0;
      gen_written[c] = 1'b0;
    end
    fill_stimulus();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_bus.valid)
      @(posedge clk);
    while (expected_words.size() != 0)
      @(posedge clk);
    // let anything stray come out before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_error($sformatf("%0d words never arrived", expected_words.size()));

    if (error_count == 0)
      $display("[adc_delta_block_encoder] OK");
    else
      $display("[adc_delta_block_encoder] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[adc_delta_block_encoder] ERROR");
    $finish;
  end

endmodule
